FILE: hw/rtl/ffre_pkg.sv
// ffre_pkg: shared types and constants of the fasta first record extractor
// no dependencies; imported by every module of the block

package ffre_pkg;

    localparam logic [7:0] CHAR_GT   = 8'h3E;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    localparam logic [1:0] PH_SEEK   = 2'd0;
    localparam logic [1:0] PH_RECORD = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [1:0] LC_NONE   = 2'd0;
    localparam logic [1:0] LC_HEADER = 2'd1;
    localparam logic [1:0] LC_DATA   = 2'd2;
    localparam logic [1:0] LC_SKIP   = 2'd3;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SEQ    = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] ST_NEXT_HEADER = 2'd0;
    localparam logic [1:0] ST_BLANK       = 2'd1;
    localparam logic [1:0] ST_STRAY       = 2'd2;
    localparam logic [1:0] ST_EOF         = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [31:0] seq_len;
        logic [15:0] discard;
    } result_t;

endpackage

FILE: hw/rtl/fasta_first_record_extractor_core.sv
// fasta_first_record_extractor_core: top level, input register, parser and result queue
// depends on ffre_pkg, ffre_parser, ffre_result_fifo
//
// channel | signals                                                  | direction
// in      | in_valid in_stall in_byte in_last                        | item in
// out     | out_valid out_stall out_kind out_byte end_status         | result out
//         | seq_length discard_count                                 |
//
// one item accepted per cycle while in_stall is low; its results are registered in the result queue before they leave
// an item yields up to two results (held byte and end marker), one leaves per cycle while out_stall is low
// in_stall is high while an item waits in the input register and the four-entry
// result queue has fewer than two free slots
// reset clears parser state, input register and queue; no clearing pass
// state returns to its reset value after every item with in_last set

module fasta_first_record_extractor_core
    import ffre_pkg::*;
#(
    parameter int LENGTH_WIDTH     = 32,
    parameter int LINE_COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  end_status,
    output logic [31:0] seq_length,
    output logic [15:0] discard_count
);

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;
    logic       room;
    logic       advance;
    logic       accept;
    logic [1:0] push_cnt;
    result_t    res0;
    result_t    res1;
    result_t    head;

    assign advance  = stage_valid_reg && room;
    assign in_stall = stage_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    assign stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= in_byte;
            stage_last_reg <= in_last;
        end
    end

    ffre_parser #(
        .LENGTH_WIDTH     (LENGTH_WIDTH),
        .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (advance),
        .step_byte  (stage_byte_reg),
        .step_last  (stage_last_reg),
        .push_cnt   (push_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    ffre_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .pop_valid (out_valid),
        .pop_stall (out_stall),
        .pop_data  (head)
    );

    assign out_kind      = head.kind;
    assign out_byte      = head.data;
    assign end_status    = head.status;
    assign seq_length    = head.seq_len;
    assign discard_count = head.discard;

`ifndef ASSERT_OFF
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> stage_valid_reg)
        else $error("input stalled with empty input register");
`endif

endmodule

FILE: hw/rtl/ffre_parser.sv
// ffre_parser: record parser state and per-item step logic, up to two results per item
// depends on ffre_pkg

module ffre_parser
    import ffre_pkg::*;
#(
    parameter int LENGTH_WIDTH     = 32,
    parameter int LINE_COUNT_WIDTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_valid,
    input  logic [7:0] step_byte,
    input  logic       step_last,
    output logic [1:0] push_cnt,
    output result_t    res0,
    output result_t    res1
);

    logic [1:0]                  phase_reg, phase_next;
    logic [1:0]                  class_reg, class_next;
    logic [7:0]                  held_char_reg, held_char_next;
    logic                        held_valid_reg, held_valid_next;
    logic [LINE_COUNT_WIDTH-1:0] line_emitted_reg, line_emitted_next;
    logic [LENGTH_WIDTH-1:0]     committed_reg, committed_next;

    always_comb
    begin
        logic                        emit;
        logic                        fin;
        logic                        fin_any;
        logic                        clear_line;
        logic [1:0]                  fin_st;
        logic [LINE_COUNT_WIDTH-1:0] le_inc;
        logic [63:0]                 len64;
        logic [63:0]                 disc64;
        result_t                     emit_rec;
        result_t                     fin_rec;

        phase_next      = phase_reg;
        class_next      = class_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        emit            = 1'b0;
        fin             = 1'b0;
        fin_any         = 1'b0;
        clear_line      = 1'b0;
        fin_st          = ST_EOF;
        len64           = 64'd0;
        disc64          = 64'd0;

        if (step_valid && phase_reg != PH_DONE)
        begin
            if (step_byte == CHAR_LF)
            begin
                case (class_reg)
                    LC_NONE:
                    begin
                        if (phase_reg == PH_RECORD)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_BLANK;
                        end
                    end
                    LC_HEADER:
                    begin
                        emit       = held_valid_reg && held_char_reg != CHAR_CR;
                        phase_next = PH_RECORD;
                    end
                    LC_DATA:
                    begin
                        if (held_valid_reg && held_char_reg == CHAR_CR
                            && line_emitted_reg == '0)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_BLANK;
                        end
                        else
                        begin
                            emit = held_valid_reg && held_char_reg != CHAR_CR;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (!fin)
                begin
                    clear_line      = 1'b1;
                    class_next      = LC_NONE;
                    held_valid_next = 1'b0;
                    held_char_next  = 8'd0;
                end
            end
            else if (class_reg == LC_NONE)
            begin
                if (step_byte == CHAR_GT)
                begin
                    if (phase_reg == PH_SEEK)
                    begin
                        class_next      = LC_HEADER;
                        held_char_next  = step_byte;
                        held_valid_next = 1'b1;
                    end
                    else
                    begin
                        fin    = 1'b1;
                        fin_st = ST_NEXT_HEADER;
                    end
                end
                else if (step_byte == CHAR_SEMI)
                begin
                    class_next = LC_SKIP;
                end
                else if (phase_reg == PH_SEEK)
                begin
                    fin    = 1'b1;
                    fin_st = ST_STRAY;
                end
                else
                begin
                    class_next      = LC_DATA;
                    held_char_next  = step_byte;
                    held_valid_next = 1'b1;
                end
            end
            else if (class_reg == LC_HEADER || class_reg == LC_DATA)
            begin
                emit            = held_valid_reg;
                held_char_next  = step_byte;
                held_valid_next = 1'b1;
            end
            fin_any = fin || step_last;
        end

        le_inc         = line_emitted_reg;
        committed_next = committed_reg;
        if (emit)
        begin
            if (line_emitted_reg != '1)
                le_inc = line_emitted_reg + 1'b1;
            if (class_reg != LC_HEADER && committed_reg != '1)
                committed_next = committed_reg + 1'b1;
        end
        line_emitted_next = clear_line ? '0 : le_inc;

        len64 = 64'(committed_next);
        if (!fin && class_next == LC_HEADER)
        begin
            disc64 = 64'(line_emitted_next);
            len64  = 64'd0;
        end
        else if (!fin && class_next == LC_DATA)
        begin
            disc64 = 64'(line_emitted_next);
            if (committed_next != '1)
                len64 = 64'(committed_next) - disc64;
        end
        if (fin_any)
            phase_next = PH_DONE;

        emit_rec.kind    = (class_reg == LC_HEADER) ? KIND_HEADER : KIND_SEQ;
        emit_rec.data    = held_char_reg;
        emit_rec.status  = 2'd0;
        emit_rec.seq_len = 32'd0;
        emit_rec.discard = 16'd0;

        fin_rec.kind    = KIND_END;
        fin_rec.data    = 8'd0;
        fin_rec.status  = fin_st;
        fin_rec.seq_len = (len64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len64[31:0];
        fin_rec.discard = (disc64 > 64'hFFFF) ? 16'hFFFF : disc64[15:0];

        push_cnt = 2'(emit) + 2'(fin_any);
        res0     = emit ? emit_rec : fin_rec;
        res1     = fin_rec;

        if (step_valid && step_last)
        begin
            phase_next        = PH_SEEK;
            class_next        = LC_NONE;
            held_char_next    = 8'd0;
            held_valid_next   = 1'b0;
            line_emitted_next = '0;
            committed_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEEK;
            class_reg        <= LC_NONE;
            held_char_reg    <= 8'd0;
            held_valid_reg   <= 1'b0;
            line_emitted_reg <= '0;
            committed_reg    <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            class_reg        <= class_next;
            held_char_reg    <= held_char_next;
            held_valid_reg   <= held_valid_next;
            line_emitted_reg <= line_emitted_next;
            committed_reg    <= committed_next;
        end
    end

`ifndef ASSERT_OFF
    a_two_results_order: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> res0.kind != KIND_END && res1.kind == KIND_END)
        else $error("two results not ordered as byte then end marker");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> push_cnt == 2'd0)
        else $error("result produced after record end");

    a_held_class: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> class_reg == LC_HEADER || class_reg == LC_DATA)
        else $error("held byte outside header or data line");
`endif

endmodule

FILE: hw/rtl/ffre_result_fifo.sv
// ffre_result_fifo: four-entry result queue; per cycle it takes up to two pushes and, while pop_stall is low, one pop
// depends on ffre_pkg

module ffre_result_fifo
    import ffre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       pop_valid,
    input  logic       pop_stall,
    output result_t    pop_data
);

    result_t     entry_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;

    assign room      = count_reg <= 3'd2;
    assign pop_valid = count_reg != 3'd0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign pop       = pop_valid && !pop_stall;

    assign wr_ptr_next = wr_ptr_reg + push_cnt;
    assign rd_ptr_next = rd_ptr_reg + 2'(pop);
    assign count_next  = 3'(count_reg + {1'b0, push_cnt} - {2'b00, pop});

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            entry_reg[wr_ptr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> 3'(count_reg + {1'b0, push_cnt}) <= 3'd4)
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        2'(rd_ptr_reg + count_reg[1:0]) == wr_ptr_reg)
        else $error("queue pointers disagree with count");
`endif

endmodule
